/* rtl/s256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Used by s256_msg, s256_core and sha256_stream_hash_unit; depends on nothing.

package s256_pkg;

  typedef logic [31:0] word_t;

  localparam int ROUNDS     = 64;
  localparam int HASH_WORDS = 8;
  localparam int SCHED_LEN  = 16;

  // Block fill positions (bytes)
  localparam logic [5:0] FILL_END = 6'd63;  // last byte of a block
  localparam logic [5:0] LEN_POS  = 6'd56;  // first byte of the length field

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Output word packing: digest word, then its index, zero filled to 40 bits
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - 32 - 3;

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t START_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Top level -> compression core
  typedef struct packed {
    logic start;  // load working vars from chain, run 64 rounds
    logic init;   // return chain to the initial hash values
  } core_cmd_t;

  // Compression core -> top level
  typedef struct packed {
    logic step;   // a round runs this cycle; advance the schedule
    logic done;   // chain is updated at this edge
  } core_stat_t;

  // Top level -> message window
  typedef struct packed {
    logic       load;  // shift one message byte in
    logic       step;  // advance the schedule by one word
    logic [7:0] data;
  } msg_cmd_t;

  function automatic word_t rotr(input word_t v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t a);
    big_sigma0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t e);
    big_sigma1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t w);
    small_sigma0 = rotr(w, 7) ^ rotr(w, 18) ^ (w >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t w);
    small_sigma1 = rotr(w, 17) ^ rotr(w, 19) ^ (w >> 10);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

/* rtl/sha256_stream_hash_unit.sv */
// SHA-256 over a byte stream: byte intake, padding sequencer and digest output.
// Byte words are taken one per cycle while idle; a block's 64th byte starts a
// compression that holds off intake. A last word then adds the padding bytes (at
// most 64, or 72 with an extra block), the compressions and the 8 digest words.
// Synchronous active-high reset: initial hash values, empty block, zero length.

module sha256_stream_hash_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tuser,  // [0] byte_valid
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [s256_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] digest_word,
                                                         // [34:32] word_index
  output logic                            m_axis_tlast
);

  typedef enum logic [2:0] {
    IDLE,
    HASH,
    PAD_ONE,
    PAD_ZERO,
    PAD_LEN,
    OUT
  } state_t;

  state_t               state;
  state_t               resume;
  state_t               follow;
  logic [5:0]           fill;
  logic [63:0]          msg_bits;
  logic [3:0]           cnt;
  logic [31:0]          out_word;
  logic [2:0]           out_idx;
  logic                 out_last;
  logic                 in_ok;
  logic                 shift_en;
  logic [7:0]           shift_byte;
  logic                 hash_go;
  logic                 take;
  s256_pkg::core_cmd_t  core_cmd;
  s256_pkg::core_stat_t core_stat;
  s256_pkg::msg_cmd_t   msg_cmd;
  s256_pkg::word_t      w_cur;
  s256_pkg::word_t      chain_word;

  assign s_axis_tready = (state == IDLE);
  assign in_ok         = s_axis_tvalid && (state == IDLE);
  assign take          = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {{s256_pkg::OUT_PAD_W{1'b0}}, out_idx, out_word};
  assign m_axis_tlast  = out_last;

  // Byte source for the window and the state that follows the byte
  always_comb begin
    shift_en   = 1'b0;
    shift_byte = 8'h00;
    follow     = state;
    unique case (state)
      IDLE: begin
        shift_en   = in_ok && s_axis_tuser;
        shift_byte = s_axis_tdata;
        follow     = (in_ok && s_axis_tlast) ? PAD_ONE : IDLE;
      end
      PAD_ONE: begin
        shift_en   = 1'b1;
        shift_byte = s256_pkg::PAD_MARK;
        follow     = PAD_ZERO;
      end
      PAD_ZERO: begin
        shift_en = (fill != s256_pkg::LEN_POS);
        follow   = (fill == s256_pkg::LEN_POS) ? PAD_LEN : PAD_ZERO;
      end
      PAD_LEN: begin
        // length bytes go out most significant first
        shift_en   = 1'b1;
        shift_byte = msg_bits[{~fill[2:0], 3'b000} +: 8];
        follow     = (fill == s256_pkg::FILL_END) ? OUT : PAD_LEN;
      end
      HASH, OUT: begin
        follow = state;
      end
      default: begin
        follow = IDLE;
      end
    endcase
  end

  assign hash_go = shift_en && (fill == s256_pkg::FILL_END);

  assign msg_cmd.load = shift_en;
  assign msg_cmd.step = core_stat.step;
  assign msg_cmd.data = shift_byte;

  assign core_cmd.start = hash_go;
  assign core_cmd.init  = (state == OUT) && take && cnt[3];

  // Sequencer, length counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      resume        <= IDLE;
      fill          <= '0;
      msg_bits      <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (shift_en) begin
        fill <= fill + 6'd1;
      end
      unique case (state)
        IDLE, PAD_ONE, PAD_ZERO, PAD_LEN: begin
          if (in_ok && s_axis_tuser) begin
            msg_bits <= msg_bits + 64'd8;
          end
          if (hash_go) begin
            state  <= HASH;
            resume <= follow;
          end else begin
            state <= follow;
          end
        end
        HASH: begin
          cnt <= '0;
          if (core_stat.done) begin
            state <= resume;
          end
        end
        OUT: begin
          if (take) begin
            if (cnt[3]) begin
              m_axis_tvalid <= 1'b0;
              msg_bits      <= '0;
              state         <= IDLE;
            end else begin
              m_axis_tvalid <= 1'b1;
              out_word      <= chain_word;
              out_idx       <= cnt[2:0];
              out_last      <= (cnt[2:0] == 3'd7);
              cnt           <= cnt + 4'd1;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  s256_msg u_msg (
    .clk   (clk),
    .cmd   (msg_cmd),
    .w_cur (w_cur)
  );

  s256_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cmd        (core_cmd),
    .w_in       (w_cur),
    .chain_sel  (cnt[2:0]),
    .chain_word (chain_word),
    .stat       (core_stat)
  );

endmodule

/* rtl/s256_msg.sv */
// Block buffer and message schedule: one 16-word window that takes message
// bytes in order and then slides to produce W[t]. Depends on s256_pkg.

module s256_msg (
  input  logic              clk,
  input  s256_pkg::msg_cmd_t cmd,
  output s256_pkg::word_t   w_cur
);

  s256_pkg::word_t win [s256_pkg::SCHED_LEN];
  s256_pkg::word_t w_new;

  // W[t+16] from the window holding W[t..t+15]
  assign w_new = win[0] + s256_pkg::small_sigma0(win[1]) + win[9]
               + s256_pkg::small_sigma1(win[14]);

  assign w_cur = win[0];

  // Byte fill shifts the whole window left by a byte; a step shifts a word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < s256_pkg::SCHED_LEN - 1; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[s256_pkg::SCHED_LEN-1] <= {win[s256_pkg::SCHED_LEN-1][23:0], cmd.data};
    end else if (cmd.step) begin
      for (int i = 0; i < s256_pkg::SCHED_LEN - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[s256_pkg::SCHED_LEN-1] <= w_new;
    end
  end

endmodule

/* rtl/s256_core.sv */
// Compression core: one shared round unit run 64 times per block over the
// working variables, then added into the chaining words. Depends on s256_pkg.

module s256_core (
  input  logic                clk,
  input  logic                rst,
  input  s256_pkg::core_cmd_t cmd,
  input  s256_pkg::word_t     w_in,
  input  logic [2:0]          chain_sel,
  output s256_pkg::word_t     chain_word,
  output s256_pkg::core_stat_t stat
);

  s256_pkg::word_t chain [s256_pkg::HASH_WORDS];
  s256_pkg::word_t v     [s256_pkg::HASH_WORDS];
  logic [5:0]      rnd;
  logic            busy;
  logic            fin;
  s256_pkg::word_t t1;
  s256_pkg::word_t t2;

  // Round arithmetic
  assign t1 = v[7] + s256_pkg::big_sigma1(v[4]) + s256_pkg::choose(v[4], v[5], v[6])
            + s256_pkg::ROUND_K[rnd] + w_in;
  assign t2 = s256_pkg::big_sigma0(v[0]) + s256_pkg::majority(v[0], v[1], v[2]);

  assign stat.step  = busy;
  assign stat.done  = fin;
  assign chain_word = chain[chain_sel];

  // Round sequencer and chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      rnd  <= '0;
      for (int i = 0; i < s256_pkg::HASH_WORDS; i++) begin
        chain[i] <= s256_pkg::START_HASH[i];
      end
    end else begin
      fin <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'(s256_pkg::ROUNDS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        for (int i = 0; i < s256_pkg::HASH_WORDS; i++) begin
          chain[i] <= chain[i] + v[i];
        end
      end
      if (cmd.init) begin
        for (int i = 0; i < s256_pkg::HASH_WORDS; i++) begin
          chain[i] <= s256_pkg::START_HASH[i];
        end
      end
    end
  end

  // Working variables a..h
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < s256_pkg::HASH_WORDS; i++) begin
        v[i] <= chain[i];
      end
    end else if (busy) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

/* verif/tb_top.sv */
// Self-checking bench for sha256_stream_hash_unit: byte words in, digest words out.
// Holds its own SHA-256 predictor and checks every digest word in order.
// Depends on rtl/s256_pkg.sv (output width) and the unit itself.

module tb_top;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 4;
  localparam int TARGET_ITEMS  = 450;
  localparam int STALL_LIMIT   = 4000;  // cycles without any accepted word
  localparam int DRAIN_CYCLES  = 300;
  localparam int BLOCK_BYTES   = 64;
  localparam int LEN_FIELD_POS = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int DIGEST_WORDS  = 8;

  // Idle phases, one per quarter of the stimulus
  typedef enum int {PH_STEADY, PH_SRC_GAPS, PH_SINK_STALLS, PH_BOTH} idle_phase_t;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } byte_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_TABLE [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b1;
  logic [s256_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;

  sha256_stream_hash_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #CLK_HALF clk = ~clk;

  byte_item_t   pending_items[$];
  digest_word_t digest_q[$];
  int           total_items    = 0;
  int           msg_items      = 0;
  int           items_accepted = 0;
  int           mismatches     = 0;
  int           idle_cycles    = 0;

  // Predictor state
  logic [31:0] chain_words [DIGEST_WORDS];
  logic [7:0]  blk_bytes [BLOCK_BYTES];
  int          blk_fill;
  logic [63:0] bit_len;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void clear_hash_state();
    for (int i = 0; i < DIGEST_WORDS; i++) chain_words[i] = IV_TABLE[i];
    blk_fill = 0;
    bit_len  = '0;
  endfunction

  // One 64-round compression of blk_bytes into chain_words
  function automatic void compress_blk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain_words[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_words[i] += v[i];
  endfunction

  // Absorb one accepted byte word; on last, pad and queue the digest
  function automatic void sha256_absorb(input byte_item_t it);
    digest_word_t d;
    if (it.valid) begin
      blk_bytes[blk_fill] = it.data;
      bit_len += 64'd8;
      blk_fill++;
      if (blk_fill == BLOCK_BYTES) begin
        compress_blk();
        blk_fill = 0;
      end
    end
    if (!it.last) return;
    blk_bytes[blk_fill] = PAD_BYTE;
    blk_fill++;
    // no room left for the length field: pad out and spend one more block
    if (blk_fill > LEN_FIELD_POS) begin
      while (blk_fill < BLOCK_BYTES) blk_bytes[blk_fill++] = 8'h00;
      compress_blk();
      blk_fill = 0;
    end
    while (blk_fill < LEN_FIELD_POS) blk_bytes[blk_fill++] = 8'h00;
    for (int i = 0; i < 8; i++) blk_bytes[BLOCK_BYTES-1-i] = bit_len[8*i +: 8];
    compress_blk();
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      d.word = chain_words[i];
      d.idx  = 3'(i);
      d.last = (i == DIGEST_WORDS - 1);
      digest_q.push_back(d);
    end
    clear_hash_state();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic idle_phase_t cur_phase();
    int p;
    p = (total_items == 0) ? 0 : (items_accepted * 4) / total_items;
    if (p > 3) p = 3;
    return idle_phase_t'(p);
  endfunction

  function automatic void push_item(input logic [7:0] data, input logic valid,
                                    input logic last);
    byte_item_t it;
    it.data  = data;
    it.valid = valid;
    it.last  = last;
    pending_items.push_back(it);
  endfunction

  // Queue one message; occasional empty words are sprinkled in as noise
  task automatic add_message(input int len, input bit close_empty);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 4) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, !close_empty && (i == len - 1));
      msg_items++;
    end
    if (close_empty) begin
      push_item(8'($urandom), 1'b0, 1'b1);
      msg_items++;
    end
  endtask

  // Driver: present the next pending byte word, with random source gaps
  always @(posedge clk) begin : byte_driver
    byte_item_t  cur, nxt;
    idle_phase_t ph;
    logic        gap;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        cur.data  = s_axis_tdata;
        cur.valid = s_axis_tuser;
        cur.last  = s_axis_tlast;
        sha256_absorb(cur);
        items_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        ph  = cur_phase();
        gap = (ph == PH_SRC_GAPS && $urandom_range(0, 99) < 45) ||
              (ph == PH_BOTH && $urandom_range(0, 99) < 17);
        if (pending_items.size() != 0 && !gap) begin
          nxt = pending_items.pop_front();
          s_axis_tdata  <= nxt.data;
          s_axis_tuser  <= nxt.valid;
          s_axis_tlast  <= nxt.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each digest word against the oldest expected one
  always @(posedge clk) begin : digest_monitor
    digest_word_t exp_w;
    idle_phase_t  ph;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h", m_axis_tdata[31:0]));
      end else begin
        exp_w = digest_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_w.word)
          report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                    m_axis_tdata[31:0], exp_w.word, exp_w.idx));
        if (m_axis_tdata[34:32] !== exp_w.idx)
          report_mismatch($sformatf("word_index %0d, expected %0d",
                                    m_axis_tdata[34:32], exp_w.idx));
        if (m_axis_tlast !== exp_w.last)
          report_mismatch($sformatf("digest_last %b, expected %b (index %0d)",
                                    m_axis_tlast, exp_w.last, exp_w.idx));
        if (m_axis_tdata[s256_pkg::OUT_DATA_W-1:35] !== '0)
          report_mismatch($sformatf("fill bits %h not zero",
                                    m_axis_tdata[s256_pkg::OUT_DATA_W-1:35]));
      end
    end
    ph = cur_phase();
    m_axis_tready <= !((ph == PH_SINK_STALLS && $urandom_range(0, 99) < 45) ||
                       (ph == PH_BOTH && $urandom_range(0, 99) < 17));
  end

  // Watchdog: cycles in which neither side moves a word
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : stimulus_and_end
    int len;
    clear_hash_state();

    // Directed: empty message, noise word, short messages, byte extremes
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'h5a, 1'b0, 1'b1);
    msg_items = 11;

    // Padding boundaries: fits, needs an extra block, full block then close
    add_message(55, 1'b0);
    add_message(56, 1'b0);
    add_message(64, 1'b1);

    // Random messages, mostly short, some near and past a block boundary
    while (msg_items < TARGET_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = 0;
        1, 2:    len = $urandom_range(50, 70);
        3:       len = $urandom_range(110, 135);
        default: len = $urandom_range(1, 12);
      endcase
      add_message(len, (len == 0) || ($urandom_range(0, 3) == 0));
    end
    total_items = pending_items.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while ((items_accepted < total_items || digest_q.size() != 0) &&
           idle_cycles < STALL_LIMIT)
      @(posedge clk);

    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (mismatches == 0 && digest_q.size() == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
    end
    $finish;
  end

endmodule

/* sha256_stream_hash_unit.f */
rtl/s256_pkg.sv
rtl/s256_msg.sv
rtl/s256_core.sv
rtl/sha256_stream_hash_unit.sv
verif/tb_top.sv
